/* src/five_stage_pipeline_core_assert.svh */
// assertion macros for the checker file of the pipeline core
// no dependencies; expects a clock named i_clk and a reset named i_rst_n in scope
`ifndef FIVE_STAGE_PIPELINE_CORE_ASSERT_SVH
`define FIVE_STAGE_PIPELINE_CORE_ASSERT_SVH

// consequent in the cycle after the antecedent, ignored while in reset
`define FSP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pipeline core check failed");

// delayed consequent, ignored while in reset
`define FSP_ASSERT_AFTER2(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##2 (cons)) \
        else $error("pipeline core check failed");

// checked during reset as well
`define FSP_ASSERT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("pipeline core check failed");

`endif

/* src/fsp_pkg.sv */
// shared types, codes and helpers of the five-stage pipeline core
// no dependencies
package fsp_pkg;

    localparam int IN_DATA_W = 48;
    localparam int OP_W      = 3;

    // input word operations
    localparam logic [OP_W-1:0] OPN_LOAD_INSTR = 3'd0;
    localparam logic [OP_W-1:0] OPN_LOAD_DATA  = 3'd1;
    localparam logic [OP_W-1:0] OPN_CLOCK      = 3'd2;
    localparam logic [OP_W-1:0] OPN_READ_REG   = 3'd3;
    localparam logic [OP_W-1:0] OPN_READ_DATA  = 3'd4;

    // instruction opcodes and function code
    localparam logic [5:0] OPC_RTYPE = 6'd0;
    localparam logic [5:0] OPC_JUMP  = 6'd2;
    localparam logic [5:0] OPC_BEQ   = 6'd4;
    localparam logic [5:0] OPC_LOAD  = 6'd35;
    localparam logic [5:0] OPC_STORE = 6'd43;
    localparam logic [5:0] FN_ADDU   = 6'd33;

    localparam logic [31:0] HALT_WORD = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [15:0] imm;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  dst;
        logic        itype;
        logic        rd;
        logic        wr;
        logic        add;
        logic        wen;
        logic        idle;
        logic        br;
    } t_ex_ctl;

    typedef struct packed {
        logic [4:0] rt;
        logic [4:0] dst;
        logic       rd;
        logic       wr;
        logic       wen;
        logic       idle;
        logic       br;
    } t_mem_ctl;

    typedef struct packed {
        logic [4:0] dst;
        logic       wen;
        logic       idle;
    } t_wb_ctl;

    // byte k of a big-endian word, k = 0 is the most significant
    function automatic logic [7:0] byte_of(input logic [31:0] w, input logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd0:    b = w[31:24];
            2'd1:    b = w[23:16];
            2'd2:    b = w[15:8];
            default: b = w[7:0];
        endcase
        return b;
    endfunction

endpackage

/* src/fsp_byte_mem.sv */
// byte-addressed word memory in four byte banks, big-endian, addresses wrap
// one word write and two word reads per cycle outside the clearing pass, read data registered; uses fsp_pkg
module fsp_byte_mem #(
    parameter int MEM_BYTES = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    output logic                         o_busy,
    input  logic                         i_we,
    input  logic [$clog2(MEM_BYTES)-1:0] i_waddr,
    input  logic [31:0]                  i_wdata,
    input  logic [$clog2(MEM_BYTES)-1:0] i_raddr_a,
    input  logic [$clog2(MEM_BYTES)-1:0] i_raddr_b,
    output logic [31:0]                  o_rdata_a,
    output logic [31:0]                  o_rdata_b
);
    import fsp_pkg::*;

    localparam int AW   = $clog2(MEM_BYTES);
    localparam int RW   = AW - 2;
    localparam int ROWS = MEM_BYTES / 4;

    logic          r_busy;
    logic [RW-1:0] r_clr_row;
    logic [1:0]    r_a0;
    logic [1:0]    r_b0;
    logic [7:0]    r_q_a [4];
    logic [7:0]    r_q_b [4];

    assign o_busy = r_busy;

    // clearing pass after reset, one row of all banks per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_row <= '0;
        end else if (r_busy) begin
            if (r_clr_row == {RW{1'b1}}) begin
                r_busy <= 1'b0;
            end
            r_clr_row <= r_clr_row + 1'b1;
        end
    end

    // byte position of each read word
    always_ff @(posedge i_clk) begin
        r_a0 <= i_raddr_a[1:0];
        r_b0 <= i_raddr_b[1:0];
    end

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [7:0]    r_mem [ROWS];
        logic [1:0]    wk, ak, bk;
        logic [AW-1:0] wsum, asum, bsum;
        logic [RW-1:0] wrow, arow, brow;
        logic [7:0]    wbyte;
        logic          we;

        // which byte of each word lands in this bank, and at which row
        always_comb begin
            wk    = 2'(b) - i_waddr[1:0];
            ak    = 2'(b) - i_raddr_a[1:0];
            bk    = 2'(b) - i_raddr_b[1:0];
            wsum  = i_waddr + AW'(wk);
            asum  = i_raddr_a + AW'(ak);
            bsum  = i_raddr_b + AW'(bk);
            arow  = asum[AW-1:2];
            brow  = bsum[AW-1:2];
            wrow  = r_busy ? r_clr_row : wsum[AW-1:2];
            wbyte = r_busy ? 8'd0 : byte_of(i_wdata, wk);
            we    = r_busy | i_we;
        end

        always_ff @(posedge i_clk) begin
            if (we) begin
                r_mem[wrow] <= wbyte;
            end
            r_q_a[b] <= (we && wrow == arow) ? wbyte : r_mem[arow];
            r_q_b[b] <= (we && wrow == brow) ? wbyte : r_mem[brow];
        end
    end

    // reassemble big-endian words
    assign o_rdata_a = {r_q_a[r_a0], r_q_a[r_a0 + 2'd1], r_q_a[r_a0 + 2'd2],
                        r_q_a[r_a0 + 2'd3]};
    assign o_rdata_b = {r_q_b[r_b0], r_q_b[r_b0 + 2'd1], r_q_b[r_b0 + 2'd2],
                        r_q_b[r_b0 + 2'd3]};

endmodule

/* src/fsp_regfile.sv */
// 32 x 32 register file, one write and two registered reads per cycle
// entries read as zero until first written after reset; no dependencies
module fsp_regfile (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_we,
    input  logic [4:0]  i_waddr,
    input  logic [31:0] i_wdata,
    input  logic [4:0]  i_raddr_a,
    input  logic [4:0]  i_raddr_b,
    output logic [31:0] o_rdata_a,
    output logic [31:0] o_rdata_b
);
    logic [31:0] r_regs [32];
    logic [31:0] r_valid;
    logic [31:0] r_q_a;
    logic [31:0] r_q_b;

    // valid bits stand in for the zero reset of the storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    // storage and registered reads with write bypass
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_regs[i_waddr] <= i_wdata;
        end
        if (i_we && i_waddr == i_raddr_a) begin
            r_q_a <= i_wdata;
        end else begin
            r_q_a <= r_valid[i_raddr_a] ? r_regs[i_raddr_a] : 32'd0;
        end
        if (i_we && i_waddr == i_raddr_b) begin
            r_q_b <= i_wdata;
        end else begin
            r_q_b <= r_valid[i_raddr_b] ? r_regs[i_raddr_b] : 32'd0;
        end
    end

    assign o_rdata_a = r_q_a;
    assign o_rdata_b = r_q_b;

endmodule

/* src/five_stage_pipeline_core.sv */
// Five-stage in-order pipeline core (addu, subu, lw, sw, beq) driven by command words.
// Input stream: tuser carries the operation (load instruction word, load data word,
// clock, read register, read data word); tdata carries byte address, word and
// register index. Each accepted word gives exactly one output word: tdata holds the
// register or data word read (zero otherwise), tuser[0] is high when every stage
// is empty after the command.
// Path: a command passes through the command register, and its result through the
// result register. Throughput: one command per cycle, clock commands included,
// while the receiver takes every result; the memories are read ahead at the
// addresses the next command will need, with write bypass, so the whole step fits
// between the command register and the result register.
// Reset: synchronous, active low. After reset both memories are zeroed by a pass
// over all their rows, during which tready stays low.
// MEM_BYTES must be a power of two. When the receiver stalls, the result holds in
// the output register and one more command is held in the command register.
// Depends on fsp_pkg, fsp_byte_mem and fsp_regfile.
module five_stage_pipeline_core #(
    parameter int MEM_BYTES = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // byte_address [9:0], word_value [41:10], register_index [46:42], zero [47]
    input  logic [fsp_pkg::IN_DATA_W-1:0] i_s_tdata,
    // operation [2:0]
    input  logic [fsp_pkg::OP_W-1:0]      i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // read_value [31:0]
    output logic [31:0]                   o_m_tdata,
    // halted [0]
    output logic [0:0]                    o_m_tuser
);
    import fsp_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);

    // command and result registers
    logic                 r_in_valid;
    logic [OP_W-1:0]      r_in_op;
    logic [IN_DATA_W-1:0] r_in_data;
    logic                 r_out_valid;
    logic [31:0]          r_out_value;
    logic                 r_out_halted;

    // pipeline state
    logic [31:0] r_pc, n_pc;
    logic        r_fetch_idle, n_fetch_idle;
    logic [31:0] r_dec_word, n_dec_word;
    logic        r_dec_idle, n_dec_idle;
    logic [31:0] r_ex_a, n_ex_a, r_ex_b, n_ex_b;
    t_ex_ctl     r_ex, n_ex;
    logic [31:0] r_mem_alu, n_mem_alu, r_mem_sv, n_mem_sv;
    t_mem_ctl    r_mc, n_mc;
    logic [31:0] r_wb_value, n_wb_value;
    t_wb_ctl     r_wc, n_wc;

    // handshake
    logic s_acc, adv, do_clk, busy_i, busy_d;

    // command fields
    logic [9:0]  in_addr;
    logic [31:0] in_word, in_addr32;
    logic [4:0]  in_ri;
    logic [OP_W-1:0]      nx_op;
    logic [IN_DATA_W-1:0] nx_data;
    logic [31:0]          nx_addr32, n_pc_m4;

    // memory ports
    logic          im_we, dm_we, rf_we;
    logic [AW-1:0] dm_waddr;
    logic [31:0]   dm_wdata;
    logic [31:0]   im_a, im_b, dm_a, dm_b, rf_a, rf_b;
    logic [4:0]    rf_ra;

    // step logic
    logic [5:0]  opc;
    logic [4:0]  rs, rt;
    logic [31:0] rf_rs, rf_rt, mem_sv, mem_v;
    logic [31:0] ex_a, ex_b, ex_r;
    logic        rtype, memop, stall, taken, fidle_c, jmp;
    logic [31:0] pc_e, fw, br_off;
    logic [31:0] rd_value;

    assign in_addr   = r_in_data[9:0];
    assign in_word   = r_in_data[41:10];
    assign in_ri     = r_in_data[46:42];
    assign in_addr32 = {22'd0, in_addr};

    assign adv        = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !busy_i && !busy_d && (!r_in_valid || adv);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign do_clk     = adv && r_in_op == OPN_CLOCK;

    // command that will sit in the command register next cycle
    assign nx_op     = s_acc ? i_s_tuser : r_in_op;
    assign nx_data   = s_acc ? i_s_tdata : r_in_data;
    assign nx_addr32 = {22'd0, nx_data[9:0]};
    assign n_pc_m4   = n_pc - 32'd4;

    // one clock of the pipeline: writeback, memory, execute, decode, fetch
    always_comb begin
        n_pc = r_pc;             n_fetch_idle = r_fetch_idle;
        n_dec_word = r_dec_word; n_dec_idle = r_dec_idle;
        n_ex_a = r_ex_a;         n_ex_b = r_ex_b;         n_ex = r_ex;
        n_mem_alu = r_mem_alu;   n_mem_sv = r_mem_sv;     n_mc = r_mc;
        n_wb_value = r_wb_value; n_wc = r_wc;

        // memory stage, store data forwarded from writeback
        mem_sv = (r_wc.dst == r_mc.rt && !r_wc.idle) ? r_wb_value : r_mem_sv;
        mem_v  = r_mc.rd ? dm_a : r_mem_alu;
        if (r_mc.wr || r_mc.br) begin
            mem_v = r_wb_value;
        end

        // execute stage, forwarding from memory over writeback
        rtype = r_ex.wen && !r_ex.itype;
        memop = r_ex.itype && r_ex.add;
        ex_a  = r_ex_a;
        ex_b  = r_ex_b;
        ex_r  = 32'd0;
        if (rtype || memop) begin
            if (r_wc.dst == r_ex.rs && !r_wc.idle && r_wc.wen) ex_a = r_wb_value;
            if (r_wc.dst == r_ex.rt && !r_wc.idle && r_wc.wen) ex_b = r_wb_value;
            if (r_mc.dst == r_ex.rs && !r_mc.idle && r_mc.wen) ex_a = r_mem_alu;
            if (r_mc.dst == r_ex.rt && !r_mc.idle && r_mc.wen) ex_b = r_mem_alu;
            if (rtype) begin
                ex_r = r_ex.add ? ex_a + ex_b : ex_a - ex_b;
            end else begin
                ex_r = ex_a + {{16{r_ex.imm[15]}}, r_ex.imm};
            end
        end

        // decode, register reads see this clock's writeback
        opc   = r_dec_word[31:26];
        rs    = r_dec_word[25:21];
        rt    = r_dec_word[20:16];
        rf_rs = (!r_wc.idle && r_wc.wen && r_wc.dst == rs) ? r_wb_value : rf_a;
        rf_rt = (!r_wc.idle && r_wc.wen && r_wc.dst == rt) ? r_wb_value : rf_b;
        stall = r_ex.itype && r_ex.rd &&
                ((opc == OPC_RTYPE && !r_ex.idle && (r_ex.rt == rs || r_ex.rt == rt)) ||
                 (opc == OPC_STORE && r_ex.rt == rs));
        taken = !r_dec_idle && opc == OPC_BEQ && rf_rs != rf_rt;
        jmp   = opc == OPC_JUMP;
        pc_e  = taken ? r_pc - 32'd4 : r_pc;
        fw    = taken ? im_b : im_a;
        br_off = taken ? {{14{r_dec_word[15]}}, r_dec_word[15:0], 2'b00} : 32'd0;
        fidle_c = r_fetch_idle;

        if (do_clk) begin
            if (!r_mc.idle) begin
                n_wb_value = mem_v;
                n_wc.dst   = r_mc.dst;
                n_wc.wen   = r_mc.wen;
                n_wc.idle  = 1'b0;
            end else begin
                n_wc.idle = 1'b1;
            end

            if (!r_ex.idle) begin
                n_mem_alu = ex_r;
                n_mem_sv  = ex_b;
                n_mc.rt   = r_ex.rt;
                n_mc.dst  = r_ex.dst;
                n_mc.rd   = r_ex.rd;
                n_mc.wr   = r_ex.wr;
                n_mc.wen  = r_ex.wen;
                n_mc.br   = r_ex.br;
                n_mc.idle = 1'b0;
            end else begin
                n_mc.idle = 1'b1;
            end

            if (!r_dec_idle) begin
                n_ex.itype = opc != OPC_RTYPE && opc != OPC_JUMP && opc != OPC_BEQ;
                n_ex.br    = opc == OPC_BEQ;
                n_ex.rd    = opc == OPC_LOAD;
                n_ex.wr    = opc == OPC_STORE;
                n_ex.wen   = !(opc == OPC_STORE || opc == OPC_BEQ || jmp);
                n_ex.rs    = rs;
                n_ex.rt    = rt;
                n_ex.add   = opc == OPC_LOAD || opc == OPC_STORE || opc == OPC_BEQ ||
                             r_dec_word[5:0] == FN_ADDU;
                n_ex.imm   = r_dec_word[15:0];
                if (opc == OPC_BEQ) begin
                    n_ex.dst = 5'd0;
                end else if (n_ex.itype) begin
                    n_ex.dst = rt;
                end else begin
                    n_ex.dst = r_dec_word[15:11];
                end
                n_ex.idle = stall;
                n_ex_a    = rf_rs;
                n_ex_b    = rf_rt;
            end else begin
                n_ex.idle = 1'b1;
            end

            // fetch, the taken branch steps back one word first
            if (!r_fetch_idle) begin
                n_dec_word = fw;
                if (fw == HALT_WORD) begin
                    fidle_c = 1'b1;
                end
                n_dec_idle = fidle_c;
                if (stall) begin
                    n_dec_word = r_dec_word;
                    n_dec_idle = r_dec_idle;
                end
                if (taken) begin
                    n_dec_idle = 1'b1;
                end
            end else begin
                n_dec_idle = 1'b1;
            end
            if (fw != HALT_WORD) begin
                n_pc = pc_e + 32'd4 + br_off;
            end
            n_fetch_idle = fidle_c;
            if (stall) begin
                n_pc = pc_e;
            end
        end
    end

    // memory write ports
    assign im_we    = adv && r_in_op == OPN_LOAD_INSTR;
    assign dm_we    = (adv && r_in_op == OPN_LOAD_DATA) || (do_clk && !r_mc.idle && r_mc.wr);
    assign dm_waddr = do_clk ? r_mem_alu[AW-1:0] : in_addr32[AW-1:0];
    assign dm_wdata = do_clk ? mem_sv : in_word;
    assign rf_we    = do_clk && !r_wc.idle && r_wc.wen;
    assign rf_ra    = (nx_op == OPN_READ_REG) ? nx_data[46:42] : n_dec_word[25:21];

    fsp_byte_mem #(.MEM_BYTES(MEM_BYTES)) u_imem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .o_busy    (busy_i),
        .i_we      (im_we),
        .i_waddr   (in_addr32[AW-1:0]),
        .i_wdata   (in_word),
        .i_raddr_a (n_pc[AW-1:0]),
        .i_raddr_b (n_pc_m4[AW-1:0]),
        .o_rdata_a (im_a),
        .o_rdata_b (im_b)
    );

    fsp_byte_mem #(.MEM_BYTES(MEM_BYTES)) u_dmem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .o_busy    (busy_d),
        .i_we      (dm_we),
        .i_waddr   (dm_waddr),
        .i_wdata   (dm_wdata),
        .i_raddr_a (n_mem_alu[AW-1:0]),
        .i_raddr_b (nx_addr32[AW-1:0]),
        .o_rdata_a (dm_a),
        .o_rdata_b (dm_b)
    );

    fsp_regfile u_rf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (rf_we),
        .i_waddr   (r_wc.dst),
        .i_wdata   (r_wb_value),
        .i_raddr_a (rf_ra),
        .i_raddr_b (n_dec_word[20:16]),
        .o_rdata_a (rf_a),
        .o_rdata_b (rf_b)
    );

    // result of the command
    always_comb begin
        case (r_in_op)
            OPN_READ_REG:  rd_value = rf_a;
            OPN_READ_DATA: rd_value = dm_b;
            default:       rd_value = 32'd0;
        endcase
    end

    // pipeline state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc         <= '0;
            r_fetch_idle <= 1'b0;
            r_dec_word   <= '0;
            r_dec_idle   <= 1'b1;
            r_ex_a       <= '0;
            r_ex_b       <= '0;
            r_ex         <= '{default: '0, add: 1'b1, idle: 1'b1};
            r_mem_alu    <= '0;
            r_mem_sv     <= '0;
            r_mc         <= '{default: '0, idle: 1'b1};
            r_wb_value   <= '0;
            r_wc         <= '{default: '0, idle: 1'b1};
        end else begin
            r_pc         <= n_pc;
            r_fetch_idle <= n_fetch_idle;
            r_dec_word   <= n_dec_word;
            r_dec_idle   <= n_dec_idle;
            r_ex_a       <= n_ex_a;
            r_ex_b       <= n_ex_b;
            r_ex         <= n_ex;
            r_mem_alu    <= n_mem_alu;
            r_mem_sv     <= n_mem_sv;
            r_mc         <= n_mc;
            r_wb_value   <= n_wb_value;
            r_wc         <= n_wc;
        end
    end

    // command register and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_acc) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_in_op   <= i_s_tuser;
            r_in_data <= i_s_tdata;
        end
        if (adv) begin
            r_out_value  <= rd_value;
            r_out_halted <= n_fetch_idle && n_dec_idle && n_ex.idle && n_mc.idle && n_wc.idle;
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = r_out_value;
    assign o_m_tuser[0] = r_out_halted;

endmodule

/* src/fsp_checker.sv */
// port-level checks of the pipeline core, bound to the top level
// uses fsp_pkg and the macros of five_stage_pipeline_core_assert.svh
`include "five_stage_pipeline_core_assert.svh"

module fsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic [0:0]  o_m_tuser
);
    import fsp_pkg::*;

    logic s_acc;
    assign s_acc = i_s_tvalid && o_s_tready;

    // a stalled result word holds
    `FSP_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable({o_m_tdata, o_m_tuser}))

    // reset starts the memory clearing pass, no input taken
    `FSP_ASSERT_ALWAYS(a_clear_after_reset, !i_rst_n, !o_s_tready)

    // an idle ready input side stays ready
    `FSP_ASSERT_NEXT(a_ready_keeps, o_s_tready && !i_s_tvalid, o_s_tready)

    // every accepted word is followed by a valid result word on the output
    `FSP_ASSERT_AFTER2(a_result_due, s_acc, o_m_tvalid)

endmodule

bind five_stage_pipeline_core fsp_checker u_fsp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
